>>> hw/rtl/dfr_pkg.sv
package dfr_pkg;

	// Framing constants
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_XOR   = 8'h20;

	// Payload store size default, and the store address width that caps it at 64 bytes
	localparam int BUFFER_BYTES_DEF = 64;
	localparam int STORE_ADDR_W     = 6;

	// Frame command queue
	localparam int CMDQ_DEPTH = 2;

	// Register map, indexed by paddr[2]
	localparam logic REG_CRC_POLY = 1'b0;
	localparam logic REG_CRC_INIT = 1'b1;

	// Reset values of the registers
	localparam logic [7:0] CRC_POLY_RST = 8'h07;
	localparam logic [7:0] CRC_INIT_RST = 8'h00;

	// How the front end treats one received byte
	typedef enum logic [2:0] {
		CLS_FLAG,
		CLS_ESC,
		CLS_LEN,
		CLS_CHECK,
		CLS_DATA
	} item_class_t;

	// Drain sequencer states
	typedef enum logic {
		DR_IDLE,
		DR_RUN
	} drain_state_t;

	// Store write port, front to back
	typedef struct packed {
		logic                    en;
		logic [STORE_ADDR_W-1:0] addr;
		logic [7:0]              data;
	} store_wr_t;

	// Frame command, front to queue
	typedef struct packed {
		logic       valid;
		logic [7:0] length;
	} cmd_push_t;

	// Back-end status seen by the front end
	typedef struct packed {
		logic busy;
		logic q_full;
	} back_status_t;

	// One CRC8 byte update, MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/dfr_front.sv
module dfr_front #(
	parameter int BUFFER_BYTES = dfr_pkg::BUFFER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_stall,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           crc_poly,
	input  logic [7:0]           crc_seed,
	input  dfr_pkg::back_status_t status,
	output dfr_pkg::store_wr_t   store_wr,
	output dfr_pkg::cmd_push_t   cmd_push
);
	import dfr_pkg::*;

	localparam int IDX_W = $clog2(BUFFER_BYTES);

	logic [IDX_W-1:0] idx_q;
	logic [7:0]       len_q;
	logic             esc_q;
	logic [7:0]       crc_q;

	item_class_t cls;
	logic [7:0]  data;
	logic        crc_match;
	logic        accept;

	// Undo the escape and classify the byte
	always_comb begin
		data = esc_q ? (rx_byte ^ ESC_XOR) : rx_byte;
		if (rx_byte == FLAG_BYTE) begin
			cls = CLS_FLAG;
		end else if (rx_byte == ESC_BYTE) begin
			cls = CLS_ESC;
		end else if (idx_q == '0 && len_q == 8'd0) begin
			cls = CLS_LEN;
		end else if (8'(idx_q) == len_q) begin
			cls = CLS_CHECK;
		end else begin
			cls = CLS_DATA;
		end
	end

	assign crc_match = (crc_q == data);

	// Hold a store write while a frame waits or drains; hold a frame when the queue is full
	assign rx_stall = (cls == CLS_DATA && status.busy) ||
		(cls == CLS_CHECK && crc_match && status.q_full);
	assign accept = rx_valid && !rx_stall;

	// Write payload bytes into the store
	assign store_wr.en   = accept && cls == CLS_DATA;
	assign store_wr.addr = STORE_ADDR_W'(idx_q);
	assign store_wr.data = data;

	// Hand a passing frame to the back end
	assign cmd_push.valid  = accept && cls == CLS_CHECK && crc_match;
	assign cmd_push.length = len_q;

	// Advance the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			len_q <= 8'd0;
			esc_q <= 1'b0;
			crc_q <= CRC_INIT_RST;
		end else if (accept) begin
			case (cls)
				CLS_FLAG: begin
					idx_q <= '0;
					len_q <= 8'd0;
					esc_q <= 1'b0;
					crc_q <= crc_seed;
				end
				CLS_ESC: begin
					esc_q <= 1'b1;
				end
				CLS_LEN: begin
					esc_q <= 1'b0;
					len_q <= data;
					crc_q <= crc8_step(crc_q, data, crc_poly);
				end
				CLS_CHECK: begin
					esc_q <= 1'b0;
					idx_q <= '0;
				end
				CLS_DATA: begin
					esc_q <= 1'b0;
					crc_q <= crc8_step(crc_q, data, crc_poly);
					if (idx_q == IDX_W'(BUFFER_BYTES - 1)) begin
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					esc_q <= esc_q;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_no_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr.en |-> !status.busy)
		else $error("store written while a frame drains");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push.valid |-> !status.q_full)
		else $error("frame pushed into a full queue");
	a_push_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push.valid |-> (cmd_push.length != 8'd0 && cmd_push.length < 8'(BUFFER_BYTES)))
		else $error("frame length out of range");
`endif

endmodule

>>> hw/rtl/dfr_cmdq.sv
module dfr_cmdq (
	input  logic               clk,
	input  logic               arst_n,
	input  dfr_pkg::cmd_push_t push,
	input  logic               pop,
	output logic [7:0]         head_length,
	output logic               empty,
	output logic               full
);
	import dfr_pkg::*;

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	logic [7:0]       entry_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty       = (count_q == '0);
	assign full        = (count_q == CNT_W'(CMDQ_DEPTH));
	assign head_length = entry_q[rd_ptr_q];
	assign do_push     = push.valid && !full;
	assign do_pop      = pop && !empty;

	// Store frame lengths
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.length;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CMDQ_DEPTH))
		else $error("queue count overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
	a_pop_changes_head: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> (rd_ptr_q != $past(rd_ptr_q)))
		else $error("pop did not advance read pointer");
`endif

endmodule

>>> hw/rtl/dfr_drain.sv
module dfr_drain #(
	parameter int BUFFER_BYTES = dfr_pkg::BUFFER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dfr_pkg::store_wr_t store_wr,
	input  logic [7:0]         q_length,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               running,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         payload_byte,
	output logic [7:0]         frame_length,
	output logic               last_of_frame
);
	import dfr_pkg::*;

	localparam int IDX_W = $clog2(BUFFER_BYTES);

	logic [7:0]       mem_q [BUFFER_BYTES];
	drain_state_t     state_q;
	drain_state_t     state_nx;
	logic [IDX_W-1:0] rd_idx_q;
	logic [7:0]       len_q;
	logic             rd_issue;
	logic             rd_last;
	logic             rd_valid_s1;
	logic [7:0]       rd_data_s1;
	logic             last_s1;
	logic             out_valid_q;
	logic [7:0]       payload_q;
	logic [7:0]       length_q;
	logic             last_q;
	logic             out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign rd_last  = ((8'(rd_idx_q) + 8'd1) == len_q);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			DR_IDLE: if (!q_empty) state_nx = DR_RUN;
			DR_RUN:  if (rd_issue && rd_last) state_nx = DR_IDLE;
			default: state_nx = DR_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		q_pop    = 1'b0;
		rd_issue = 1'b0;
		case (state_q)
			DR_IDLE: q_pop = !q_empty;
			DR_RUN:  rd_issue = !rd_valid_s1 && out_free;
			default: begin
				q_pop    = 1'b0;
				rd_issue = 1'b0;
			end
		endcase
	end

	assign running = (state_q == DR_RUN);

	// Payload store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			mem_q[store_wr.addr[IDX_W-1:0]] <= store_wr.data;
		end
		if (rd_issue) begin
			rd_data_s1 <= mem_q[rd_idx_q];
			last_s1    <= rd_last;
		end
	end

	// Load frame, advance read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DR_IDLE;
			rd_idx_q    <= '0;
			len_q       <= 8'd0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_nx;
			rd_valid_s1 <= rd_issue;
			if (q_pop) begin
				len_q    <= q_length;
				rd_idx_q <= '0;
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// Output register: take read data, drop it on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_valid_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			payload_q <= rd_data_s1;
			length_q  <= len_q;
			last_q    <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = payload_q;
	assign frame_length  = length_q;
	assign last_of_frame = last_q;

`ifndef SYNTH
	a_s1_finds_room: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> out_free)
		else $error("read data arrived at a full output register");
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		running |-> (len_q != 8'd0 && 8'(rd_idx_q) < len_q))
		else $error("read index beyond frame length");
	a_no_back_to_back_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> !rd_issue)
		else $error("read issued while read data pending");
	a_no_write_during_run: assert property (@(posedge clk) disable iff (!arst_n)
		running |-> !store_wr.en)
		else $error("store written while draining");
`endif

endmodule

>>> hw/rtl/escaped_length_crc8_deframer_unit.sv
// Channel   Direction  Handshake             Payload
// rx        in         rx_valid / rx_stall   rx_byte
// out       out        out_valid / out_stall payload_byte, frame_length, last_of_frame
// apb       in/out     psel, penable, pready crc_polynomial at 0x0, crc_initial at 0x4
//
// The front end takes one received byte per cycle while it does not stall; a payload
// byte is stalled while a passed frame still waits or is read out of the store, so a
// frame arriving right after one that passed takes its first payload byte only once
// that frame has drained. The drain reads the store through its registered read port
// into a single output register and issues a new read only once the previous one has
// left the port and the register is free. A frame is queued when its check byte is
// accepted; the drain then pops it, reads its first byte and offers it from the output
// register. Reset clears all control state at once; the store needs no clearing pass.
module escaped_length_crc8_deframer_unit #(
	parameter int BUFFER_BYTES = dfr_pkg::BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic [7:0]  frame_length,
	output logic        last_of_frame,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dfr_pkg::*;

	logic [7:0]   crc_poly_q;
	logic [7:0]   crc_seed_q;
	logic         cfg_write;
	store_wr_t    store_wr;
	cmd_push_t    cmd_push;
	back_status_t status;
	logic [7:0]   q_length;
	logic         q_empty;
	logic         q_full;
	logic         q_pop;
	logic         running;

	// Register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= CRC_POLY_RST;
			crc_seed_q <= CRC_INIT_RST;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_CRC_POLY: crc_poly_q <= pwdata[7:0];
				REG_CRC_INIT: crc_seed_q <= pwdata[7:0];
				default:      crc_poly_q <= crc_poly_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CRC_POLY: prdata = {24'd0, crc_poly_q};
			REG_CRC_INIT: prdata = {24'd0, crc_seed_q};
			default:      prdata = 32'd0;
		endcase
	end

	// Back end is busy while any frame waits or drains
	assign status.busy   = running || !q_empty;
	assign status.q_full = q_full;

	dfr_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.crc_poly (crc_poly_q),
		.crc_seed (crc_seed_q),
		.status   (status),
		.store_wr (store_wr),
		.cmd_push (cmd_push)
	);

	dfr_cmdq u_cmdq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (cmd_push),
		.pop         (q_pop),
		.head_length (q_length),
		.empty       (q_empty),
		.full        (q_full)
	);

	dfr_drain #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_drain (
		.clk           (clk),
		.arst_n        (arst_n),
		.store_wr      (store_wr),
		.q_length      (q_length),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.running       (running),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.frame_length  (frame_length),
		.last_of_frame (last_of_frame)
	);

endmodule
